>>> rtl/core/pas_pkg.sv
// ----------------------------------------------------------------------------
// pas_pkg
// Shared constants and types for the packet arrival statistics unit.
// ----------------------------------------------------------------------------
package pas_pkg;

	// Fixed field widths of one packet event.
	localparam int RSSI_W = 8;
	localparam int MODE_W = 2;
	localparam int RATE_W = 8;
	localparam int ANT_W  = 1;

	// Histogram sizes for the signal-mode and antenna bins.
	localparam int MODE_BINS = 4;
	localparam int ANT_BINS  = 2;

	// Pipeline control seen by the rate histogram.
	typedef struct packed {
		logic rd_en;  // an event is accepted this cycle
		logic adv;    // the stage-1 event moves to the output register
	} pas_ctl_t;

endpackage

>>> rtl/core/pas_ram.sv
// ----------------------------------------------------------------------------
// pas_ram
// Generic single-write, single-read RAM with a registered read port.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module pas_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/core/pas_rate_hist.sv
// ----------------------------------------------------------------------------
// pas_rate_hist
// Rate-code histogram held in a RAM with per-bin valid bits.
// The read starts when an event is accepted; the count is incremented and
// written back when that event leaves stage 1.
// ----------------------------------------------------------------------------
module pas_rate_hist #(
	parameter int RATE_BINS  = 256,
	parameter int COUNT_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pas_pkg::pas_ctl_t             ctl,
	input  logic [pas_pkg::RATE_W-1:0]    rate_code,
	output logic [COUNT_BITS-1:0]         bin_count
);

	localparam int AW = (RATE_BINS > 1) ? $clog2(RATE_BINS) : 1;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic [RATE_BINS-1:0]  bin_vld_q;
	logic [AW-1:0]         idx_in;
	logic                  rng_in;
	logic                  rd_vld;
	logic [AW-1:0]         idx_s1;
	logic                  rng_s1;
	logic                  vld_s1;
	logic                  byp_s1;
	logic [COUNT_BITS-1:0] byp_data_s1;
	logic [COUNT_BITS-1:0] ram_rdata;
	logic [COUNT_BITS-1:0] base;
	logic                  wr_en;

	// Codes at or above the bin count fall outside the histogram.
	assign rng_in = ({1'b0, rate_code} < (pas_pkg::RATE_W + 1)'(RATE_BINS));
	assign idx_in = rate_code[AW-1:0];
	assign rd_vld = rng_in && bin_vld_q[idx_in];
	assign wr_en  = ctl.adv && rng_s1;

	// Read side of stage 1; a write in the same cycle is forwarded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rng_s1 <= 1'b0;
			vld_s1 <= 1'b0;
			byp_s1 <= 1'b0;
		end else if (ctl.rd_en) begin
			rng_s1 <= rng_in;
			vld_s1 <= rd_vld;
			byp_s1 <= wr_en && rng_in && (idx_s1 == idx_in);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			idx_s1      <= idx_in;
			byp_data_s1 <= bin_count;
		end
	end

	// Valid bits make a never-written bin read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_vld_q <= '0;
		end else if (wr_en) begin
			bin_vld_q[idx_s1] <= 1'b1;
		end
	end

	// Saturating increment of the selected bin; an out-of-range code gives zero.
	always_comb begin
		if (byp_s1) begin
			base = byp_data_s1;
		end else if (vld_s1) begin
			base = ram_rdata;
		end else begin
			base = '0;
		end
		if (!rng_s1) begin
			bin_count = '0;
		end else if (base == CNT_MAX) begin
			bin_count = base;
		end else begin
			bin_count = base + 1'b1;
		end
	end

	pas_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (RATE_BINS)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (idx_s1),
		.wdata (bin_count),
		.re    (ctl.rd_en),
		.raddr (idx_in),
		.rdata (ram_rdata)
	);

endmodule

>>> rtl/core/pas_stats.sv
// ----------------------------------------------------------------------------
// pas_stats
// Running packet figures: count, first and previous time, signal-strength
// and interval bounds, and the signal-mode and antenna histograms.
// ----------------------------------------------------------------------------
module pas_stats #(
	parameter int TIME_BITS  = 48,
	parameter int COUNT_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic [TIME_BITS-1:0]              timestamp_us,
	input  logic signed [pas_pkg::RSSI_W-1:0] rssi_dbm,
	input  logic [pas_pkg::MODE_W-1:0]        signal_mode,
	input  logic [pas_pkg::ANT_W-1:0]         antenna,
	output logic [COUNT_BITS-1:0]             record_index,
	output logic [COUNT_BITS-1:0]             packet_total,
	output logic [TIME_BITS-1:0]              first_time_us,
	output logic signed [pas_pkg::RSSI_W-1:0] rssi_low,
	output logic signed [pas_pkg::RSSI_W-1:0] rssi_high,
	output logic [TIME_BITS-1:0]              gap_low_us,
	output logic [TIME_BITS-1:0]              gap_high_us,
	output logic [COUNT_BITS-1:0]             mode_bin_count,
	output logic [COUNT_BITS-1:0]             antenna_bin_count
);

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

	logic [COUNT_BITS-1:0]             cnt_q;
	logic [TIME_BITS-1:0]              first_q;
	logic [TIME_BITS-1:0]              prev_q;
	logic signed [pas_pkg::RSSI_W-1:0] rlo_q;
	logic signed [pas_pkg::RSSI_W-1:0] rhi_q;
	logic [TIME_BITS-1:0]              glo_q;
	logic [TIME_BITS-1:0]              ghi_q;
	logic [COUNT_BITS-1:0]             mode_q [pas_pkg::MODE_BINS];
	logic [COUNT_BITS-1:0]             ant_q [pas_pkg::ANT_BINS];
	logic [TIME_BITS-1:0]              gap;
	logic [COUNT_BITS-1:0]             mode_old;
	logic [COUNT_BITS-1:0]             ant_old;

	// Interval wraps with the timestamp width.
	assign gap = timestamp_us - prev_q;

	// Next values of all running figures for the stage-1 event.
	always_comb begin
		record_index = cnt_q;
		packet_total = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1;
		mode_old     = mode_q[signal_mode];
		ant_old      = ant_q[antenna];
		mode_bin_count    = (mode_old == CNT_MAX) ? mode_old : mode_old + 1'b1;
		antenna_bin_count = (ant_old == CNT_MAX) ? ant_old : ant_old + 1'b1;
		if (cnt_q == '0) begin
			// The first packet seeds the signal-strength bounds and zeroes the interval bounds.
			first_time_us = timestamp_us;
			rssi_low      = rssi_dbm;
			rssi_high     = rssi_dbm;
			gap_low_us    = '0;
			gap_high_us   = '0;
		end else begin
			first_time_us = first_q;
			rssi_low      = (rssi_dbm < rlo_q) ? rssi_dbm : rlo_q;
			rssi_high     = (rssi_dbm > rhi_q) ? rssi_dbm : rhi_q;
			if (cnt_q == CNT_ONE) begin
				// The second packet seeds the interval bounds.
				gap_low_us  = gap;
				gap_high_us = gap;
			end else begin
				gap_low_us  = (gap < glo_q) ? gap : glo_q;
				gap_high_us = (gap > ghi_q) ? gap : ghi_q;
			end
		end
	end

	// State update when the event completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			first_q <= '0;
			prev_q  <= '0;
			rlo_q   <= '0;
			rhi_q   <= '0;
			glo_q   <= '0;
			ghi_q   <= '0;
			for (int i = 0; i < pas_pkg::MODE_BINS; i++) begin
				mode_q[i] <= '0;
			end
			for (int i = 0; i < pas_pkg::ANT_BINS; i++) begin
				ant_q[i] <= '0;
			end
		end else if (adv) begin
			cnt_q                <= packet_total;
			first_q              <= first_time_us;
			prev_q               <= timestamp_us;
			rlo_q                <= rssi_low;
			rhi_q                <= rssi_high;
			glo_q                <= gap_low_us;
			ghi_q                <= gap_high_us;
			mode_q[signal_mode]  <= mode_bin_count;
			ant_q[antenna]       <= antenna_bin_count;
		end
	end

endmodule

>>> rtl/core/packet_arrival_statistics_unit.sv
// ----------------------------------------------------------------------------
// packet_arrival_statistics_unit
// Running statistics over received-packet events with one result per event.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  input     in_valid / in_ready    timestamp_us, rssi_dbm, signal_mode,
//                                   rate_code, antenna
//  output    out_valid / out_ready  record_index .. antenna_bin_count
//
// One event is accepted per cycle while in_ready is high. Its result passes
// through stage 1, then the output register. The rate-histogram RAM read
// starts at acceptance and the write-back happens when the event leaves
// stage 1.
// Reset clears all counts, bounds and the rate-bin valid bits at once.
// When stage 1 is occupied and the output register holds an untaken result,
// stage 1 holds and in_ready drops in the same cycle.
// ----------------------------------------------------------------------------
module packet_arrival_statistics_unit #(
	parameter int RATE_BINS  = 256,
	parameter int TIME_BITS  = 48,
	parameter int COUNT_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [TIME_BITS-1:0]              timestamp_us,
	input  logic signed [pas_pkg::RSSI_W-1:0] rssi_dbm,
	input  logic [pas_pkg::MODE_W-1:0]        signal_mode,
	input  logic [pas_pkg::RATE_W-1:0]        rate_code,
	input  logic [pas_pkg::ANT_W-1:0]         antenna,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [COUNT_BITS-1:0]             record_index,
	output logic [COUNT_BITS-1:0]             packet_total,
	output logic [TIME_BITS-1:0]              first_time_us,
	output logic signed [pas_pkg::RSSI_W-1:0] rssi_low,
	output logic signed [pas_pkg::RSSI_W-1:0] rssi_high,
	output logic [TIME_BITS-1:0]              gap_low_us,
	output logic [TIME_BITS-1:0]              gap_high_us,
	output logic [COUNT_BITS-1:0]             mode_bin_count,
	output logic [COUNT_BITS-1:0]             rate_bin_count,
	output logic [COUNT_BITS-1:0]             antenna_bin_count
);

	pas_pkg::pas_ctl_t                 ctl;
	logic                              vld_s1;
	logic [TIME_BITS-1:0]              ts_s1;
	logic signed [pas_pkg::RSSI_W-1:0] rssi_s1;
	logic [pas_pkg::MODE_W-1:0]        mode_s1;
	logic [pas_pkg::ANT_W-1:0]         ant_s1;
	logic                              out_vld_q;
	logic [COUNT_BITS-1:0]             nx_index;
	logic [COUNT_BITS-1:0]             nx_total;
	logic [TIME_BITS-1:0]              nx_first;
	logic signed [pas_pkg::RSSI_W-1:0] nx_rlo;
	logic signed [pas_pkg::RSSI_W-1:0] nx_rhi;
	logic [TIME_BITS-1:0]              nx_glo;
	logic [TIME_BITS-1:0]              nx_ghi;
	logic [COUNT_BITS-1:0]             nx_mode;
	logic [COUNT_BITS-1:0]             nx_rate;
	logic [COUNT_BITS-1:0]             nx_ant;

	// Stage 1 moves on when the output register is empty or being emptied.
	assign ctl.adv   = vld_s1 && (!out_vld_q || out_ready);
	assign in_ready  = !vld_s1 || ctl.adv;
	assign ctl.rd_en = in_valid && in_ready;
	assign out_valid = out_vld_q;

	// Stage-1 event register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			ts_s1   <= timestamp_us;
			rssi_s1 <= rssi_dbm;
			mode_s1 <= signal_mode;
			ant_s1  <= antenna;
		end
	end

	pas_stats #(
		.TIME_BITS  (TIME_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_stats (
		.clk               (clk),
		.arst_n            (arst_n),
		.adv               (ctl.adv),
		.timestamp_us      (ts_s1),
		.rssi_dbm          (rssi_s1),
		.signal_mode       (mode_s1),
		.antenna           (ant_s1),
		.record_index      (nx_index),
		.packet_total      (nx_total),
		.first_time_us     (nx_first),
		.rssi_low          (nx_rlo),
		.rssi_high         (nx_rhi),
		.gap_low_us        (nx_glo),
		.gap_high_us       (nx_ghi),
		.mode_bin_count    (nx_mode),
		.antenna_bin_count (nx_ant)
	);

	pas_rate_hist #(
		.RATE_BINS  (RATE_BINS),
		.COUNT_BITS (COUNT_BITS)
	) u_rate_hist (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.rate_code (rate_code),
		.bin_count (nx_rate)
	);

	// Output register; a result stays until its transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ctl.adv) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			record_index      <= nx_index;
			packet_total      <= nx_total;
			first_time_us     <= nx_first;
			rssi_low          <= nx_rlo;
			rssi_high         <= nx_rhi;
			gap_low_us        <= nx_glo;
			gap_high_us       <= nx_ghi;
			mode_bin_count    <= nx_mode;
			rate_bin_count    <= nx_rate;
			antenna_bin_count <= nx_ant;
		end
	end

`ifndef SYNTH
	// A held stage-1 event must block new transfers.
	a_no_accept_on_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !ctl.adv |-> !ctl.rd_en)
		else $error("event accepted while stage 1 is held");

	// The total is one past the index unless the count is saturated.
	a_total_follows_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (packet_total == record_index + 1'b1)
			|| ((&record_index) && (&packet_total)))
		else $error("packet total does not follow record index");

	// Signal-strength bounds stay ordered.
	a_rssi_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> rssi_low <= rssi_high)
		else $error("signal-strength bounds out of order");

	// Interval bounds stay ordered.
	a_gap_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> gap_low_us <= gap_high_us)
		else $error("interval bounds out of order");
`endif

endmodule
